// ----- rtl/q2rpy_pkg.sv -----
package q2rpy_pkg;

    localparam int TERM_W     = 32;
    localparam int SUM_W      = 35;
    localparam int VEC_W      = 36;
    localparam int ANG_W      = 35;
    localparam int RAD_W      = 62;
    localparam int SQRT_STEPS = 31;
    localparam int ROOT_W     = 31;
    localparam int ATAN_N     = 32;

    localparam logic signed [ANG_W-1:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [SUM_W-1:0] ONE_Q30     = 35'sd1073741824;
    localparam logic signed [14:0]      HALF_PI_Q13 = 15'sd12868;

    // atan(2^-i) scaled by 2^30, truncated.
    localparam logic [31:0] ATAN_TAB [ATAN_N] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
        32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [ANG_W-1:0] z;
        logic                    zero;
    } vec_t;

    typedef struct packed {
        logic [RAD_W-1:0] rem;
        logic [RAD_W-1:0] root;
    } sqrt_t;

    typedef struct packed {
        logic signed [TERM_W-1:0] sr;
        logic signed [TERM_W-1:0] cr;
        logic signed [TERM_W-1:0] sp;
        logic signed [TERM_W-1:0] sy;
        logic signed [TERM_W-1:0] cy;
        logic                     clamp;
    } terms_t;

endpackage

// ----- rtl/q2rpy_sqrt_cell.sv -----
module q2rpy_sqrt_cell #(
    parameter int POS = 0
) (
    input  logic              clk,
    input  logic              en,
    input  q2rpy_pkg::sqrt_t  d,
    output q2rpy_pkg::sqrt_t  q_reg
);

    localparam int W = q2rpy_pkg::RAD_W;
    localparam logic [W-1:0] BIT = W'(1) << (2 * POS);

    logic [W-1:0]     trial;
    q2rpy_pkg::sqrt_t q_next;

    // One result bit of the restoring square root per cell.
    always_comb
    begin
        trial = d.root + BIT;
        if (d.rem >= trial)
        begin
            q_next.rem  = d.rem - trial;
            q_next.root = (d.root >> 1) + BIT;
        end
        else
        begin
            q_next.rem  = d.rem;
            q_next.root = d.root >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

endmodule

// ----- rtl/q2rpy_cordic_cell.sv -----
module q2rpy_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic             clk,
    input  logic             en,
    input  q2rpy_pkg::vec_t  d,
    output q2rpy_pkg::vec_t  q_reg
);

    localparam int AW = q2rpy_pkg::ANG_W;
    localparam logic [31:0] ATAN = q2rpy_pkg::ATAN_TAB[STEP];
    localparam logic signed [AW-1:0] ANG = AW'(ATAN);

    logic signed [q2rpy_pkg::VEC_W-1:0] dx;
    logic signed [q2rpy_pkg::VEC_W-1:0] dy;
    q2rpy_pkg::vec_t                    q_next;

    always_comb
    begin
        dx          = d.y >>> STEP;
        dy          = d.x >>> STEP;
        q_next.zero = d.zero;
        if (!d.y[q2rpy_pkg::VEC_W-1])
        begin
            q_next.x = d.x + dx;
            q_next.y = d.y - dy;
            q_next.z = d.z + ANG;
        end
        else
        begin
            q_next.x = d.x - dx;
            q_next.y = d.y + dy;
            q_next.z = d.z - ANG;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

endmodule

// ----- rtl/quaternion_to_roll_pitch_yaw.sv -----
// Throughput: one item per cycle while the output is not stalled; the
// square root and the arctangent are fully unrolled rows of cells, one
// cell per result bit or rotation step.
// The whole pipeline holds while a finished result is stalled at the output.
// Reset clears only the valid bits; data registers are not reset.
module quaternion_to_roll_pitch_yaw #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    input  logic signed [15:0] quat_w,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] roll_angle,
    output logic signed [14:0] pitch_angle,
    output logic signed [15:0] yaw_angle,
    output logic               pitch_clamped
);

    localparam int NUM  = (CORDIC_STAGES < q2rpy_pkg::ATAN_N) ? CORDIC_STAGES
                                                              : q2rpy_pkg::ATAN_N;
    localparam int SQ   = q2rpy_pkg::SQRT_STEPS;
    localparam int L    = NUM + SQ + 5;
    localparam int TW   = q2rpy_pkg::TERM_W;
    localparam int SW   = q2rpy_pkg::SUM_W;
    localparam int VW   = q2rpy_pkg::VEC_W;
    localparam int AW   = q2rpy_pkg::ANG_W;
    localparam int RW   = q2rpy_pkg::RAD_W;

    logic         adv;
    logic [L-1:0] valid_reg;
    logic [L-1:0] valid_next;

    assign adv       = !(valid_reg[L-1] && out_stall);
    assign in_stall  = !adv;
    assign out_valid = valid_reg[L-1];

    always_comb
    begin
        valid_next = {valid_reg[L-2:0], in_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
        end
    end

    // Products of the quaternion components.
    logic signed [TW-1:0] p_xx_reg, p_yy_reg, p_zz_reg, p_wx_reg, p_yz_reg;
    logic signed [TW-1:0] p_wy_reg, p_zx_reg, p_wz_reg, p_xy_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_xx_reg <= quat_x * quat_x;
            p_yy_reg <= quat_y * quat_y;
            p_zz_reg <= quat_z * quat_z;
            p_wx_reg <= quat_w * quat_x;
            p_yz_reg <= quat_y * quat_z;
            p_wy_reg <= quat_w * quat_y;
            p_zx_reg <= quat_z * quat_x;
            p_wz_reg <= quat_w * quat_z;
            p_xy_reg <= quat_x * quat_y;
        end
    end

    function automatic logic signed [TW-1:0] sat_term(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] hi;
        logic signed [SW-1:0] lo;
        hi = SW'(34'sh07FFFFFFF);
        lo = -hi - SW'(1);
        if (v > hi)
        begin
            return {1'b0, {(TW-1){1'b1}}};
        end
        else if (v < lo)
        begin
            return {1'b1, {(TW-1){1'b0}}};
        end
        else
        begin
            return v[TW-1:0];
        end
    endfunction

    q2rpy_pkg::terms_t terms_reg;
    q2rpy_pkg::terms_t terms_next;

    always_comb
    begin
        terms_next.sr    = sat_term((SW'(p_wx_reg) + SW'(p_yz_reg)) <<< 1);
        terms_next.cr    = sat_term(q2rpy_pkg::ONE_Q30
                                    - ((SW'(p_xx_reg) + SW'(p_yy_reg)) <<< 1));
        terms_next.sp    = sat_term((SW'(p_wy_reg) - SW'(p_zx_reg)) <<< 1);
        terms_next.sy    = sat_term((SW'(p_wz_reg) + SW'(p_xy_reg)) <<< 1);
        terms_next.cy    = sat_term(q2rpy_pkg::ONE_Q30
                                    - ((SW'(p_yy_reg) + SW'(p_zz_reg)) <<< 1));
        terms_next.clamp = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            terms_reg <= terms_next;
        end
    end

    // Radicand 1 - s*s for the cosine of pitch; unused when the sine is clamped.
    logic [TW-1:0]     sp_mag;
    logic [59:0]       mag_sq;
    q2rpy_pkg::sqrt_t  sq_in;
    q2rpy_pkg::terms_t side_in;

    always_comb
    begin
        sp_mag        = terms_reg.sp[TW-1] ? TW'(-terms_reg.sp) : TW'(terms_reg.sp);
        mag_sq        = sp_mag[29:0] * sp_mag[29:0];
        sq_in.rem     = (RW'(1) << 60) - RW'(mag_sq);
        sq_in.root    = '0;
        side_in       = terms_reg;
        side_in.clamp = (terms_reg.sp >= 32'sh40000000)
                        || (terms_reg.sp <= -32'sh40000000);
    end

    q2rpy_pkg::sqrt_t  sq_reg [SQ+1];
    q2rpy_pkg::terms_t side_reg [SQ+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_reg[0]   <= sq_in;
            side_reg[0] <= side_in;
            for (int k = 0; k < SQ; k++)
            begin
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    for (genvar k = 0; k < SQ; k++)
    begin : g_sqrt
        q2rpy_sqrt_cell #(.POS(SQ - 1 - k)) u_cell (
            .clk   (clk),
            .en    (adv),
            .d     (sq_reg[k]),
            .q_reg (sq_reg[k+1])
        );
    end

    // Quadrant fold: vectors in the left half plane are turned by pi first.
    function automatic q2rpy_pkg::vec_t fold(input logic signed [VW-1:0] y,
                                             input logic signed [VW-1:0] x);
        q2rpy_pkg::vec_t v;
        v.zero = (x == '0) && (y == '0);
        if (x[VW-1])
        begin
            v.x = -x;
            v.y = -y;
            v.z = y[VW-1] ? -q2rpy_pkg::PI_Q30 : q2rpy_pkg::PI_Q30;
        end
        else
        begin
            v.x = x;
            v.y = y;
            v.z = '0;
        end
        return v;
    endfunction

    q2rpy_pkg::terms_t side_last;
    q2rpy_pkg::vec_t   lane_in [3];

    always_comb
    begin
        side_last  = side_reg[SQ];
        lane_in[0] = fold(VW'(side_last.sr), VW'(side_last.cr));
        lane_in[1] = fold(VW'(side_last.sp),
                          VW'({1'b0, sq_reg[SQ].root[q2rpy_pkg::ROOT_W-1:0]}));
        lane_in[2] = fold(VW'(side_last.sy), VW'(side_last.cy));
    end

    q2rpy_pkg::vec_t vec_reg [3][NUM+1];
    logic            clamp_reg [NUM+1];
    logic            clamp_neg_reg [NUM+1];

    // The sign of the sine travels with the clamp flag, since the rotated
    // vector no longer carries it at the end of the row.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 3; j++)
            begin
                vec_reg[j][0] <= lane_in[j];
            end
            clamp_reg[0]     <= side_last.clamp;
            clamp_neg_reg[0] <= side_last.sp[TW-1];
            for (int k = 0; k < NUM; k++)
            begin
                clamp_reg[k+1]     <= clamp_reg[k];
                clamp_neg_reg[k+1] <= clamp_neg_reg[k];
            end
        end
    end

    for (genvar j = 0; j < 3; j++)
    begin : g_lane
        for (genvar k = 0; k < NUM; k++)
        begin : g_step
            q2rpy_cordic_cell #(.STEP(k)) u_cell (
                .clk   (clk),
                .en    (adv),
                .d     (vec_reg[j][k]),
                .q_reg (vec_reg[j][k+1])
            );
        end
    end

    // Round 30 fraction bits to 13, half away from zero.
    function automatic logic signed [15:0] to_q13(input q2rpy_pkg::vec_t v);
        logic signed [AW:0] a;
        logic signed [AW:0] r;
        a = (AW+1)'(v.z);
        if (!a[AW])
        begin
            r = (a + 36'sd65536) >>> 17;
        end
        else
        begin
            r = -((-a + 36'sd65536) >>> 17);
        end
        return v.zero ? 16'sd0 : r[15:0];
    endfunction

    logic signed [15:0] roll_reg;
    logic signed [14:0] pitch_reg;
    logic signed [15:0] yaw_reg;
    logic               clamp_out_reg;
    logic signed [15:0] pitch_full;
    logic signed [14:0] pitch_next;

    always_comb
    begin
        pitch_full = to_q13(vec_reg[1][NUM]);
        if (clamp_reg[NUM])
        begin
            pitch_next = clamp_neg_reg[NUM] ? -q2rpy_pkg::HALF_PI_Q13
                                            : q2rpy_pkg::HALF_PI_Q13;
        end
        else
        begin
            pitch_next = pitch_full[14:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            roll_reg      <= to_q13(vec_reg[0][NUM]);
            pitch_reg     <= pitch_next;
            yaw_reg       <= to_q13(vec_reg[2][NUM]);
            clamp_out_reg <= clamp_reg[NUM];
        end
    end

    assign roll_angle    = roll_reg;
    assign pitch_angle   = pitch_reg;
    assign yaw_angle     = yaw_reg;
    assign pitch_clamped = clamp_out_reg;

    a_clamp_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && pitch_clamped) |->
            (pitch_angle == 15'sd12868 || pitch_angle == -15'sd12868))
        else $error("clamped pitch is not plus or minus pi/2");

    a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (roll_angle <= 16'sd25736 && roll_angle >= -16'sd25736))
        else $error("roll out of range");

    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pitch_angle <= 15'sd12868 && pitch_angle >= -15'sd12868))
        else $error("pitch out of range");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(valid_reg))
        else $error("pipeline moved while the output item was stalled");

endmodule

// ----- bench/quaternion_to_roll_pitch_yaw_checker.sv -----
module quaternion_to_roll_pitch_yaw_checker #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    input  logic signed [15:0] quat_w,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [15:0] roll_angle,
    input  logic signed [14:0] pitch_angle,
    input  logic signed [15:0] yaw_angle,
    input  logic               pitch_clamped,
    output int                 fail_count,
    output int                 pending,
    output int                 angles_seen,
    output int                 clamps_seen
);

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [15:0] yaw;
        logic               clamped;
    } euler_t;

    localparam longint ONE_Q30  = 64'sd1073741824;
    localparam longint PI_Q30   = 64'sd3373259426;
    localparam longint HALF_PI  = 64'sd12868;
    localparam longint TERM_MAX = 64'sd2147483647;
    localparam longint TERM_MIN = -64'sd2147483648;

    longint angle_step [32] = '{
        'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
        'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
        'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
        'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
        'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002,
        'h00000001, 'h00000000
    };

    euler_t angles_due [$];

    function automatic longint clip_term(longint v);
        if (v > TERM_MAX)
            return TERM_MAX;
        if (v < TERM_MIN)
            return TERM_MIN;
        return v;
    endfunction

    // Arithmetic shift on a longint floors, as the hardware does.
    function automatic longint vector_angle(longint y, longint x);
        longint z;
        longint dx;
        longint dy;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            z = (y >= 0) ? PI_Q30 : -PI_Q30;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STAGES && i < 32; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx;
                y -= dy;
                z += angle_step[i];
            end
            else
            begin
                x -= dx;
                y += dy;
                z -= angle_step[i];
            end
        end
        return z;
    endfunction

    function automatic longint round_q13(longint a);
        if (a >= 0)
            return (a + 65536) >>> 17;
        return -((-a + 65536) >>> 17);
    endfunction

    function automatic longint floor_root(longint unsigned v);
        longint unsigned rem;
        longint unsigned res;
        longint unsigned b;
        rem = v;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (rem >= res + b)
            begin
                rem -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic euler_t predict_euler(longint qx, longint qy, longint qz, longint qw);
        euler_t e;
        longint sr, cr, sp, sy, cy, mag, pitch;
        sr = clip_term(2 * (qw * qx + qy * qz));
        cr = clip_term(ONE_Q30 - 2 * (qx * qx + qy * qy));
        sp = clip_term(2 * (qw * qy - qz * qx));
        sy = clip_term(2 * (qw * qz + qx * qy));
        cy = clip_term(ONE_Q30 - 2 * (qy * qy + qz * qz));
        e.roll = 16'(round_q13(vector_angle(sr, cr)));
        e.yaw = 16'(round_q13(vector_angle(sy, cy)));
        if (sp >= ONE_Q30 || sp <= -ONE_Q30)
        begin
            pitch = (sp > 0) ? HALF_PI : -HALF_PI;
            e.clamped = 1'b1;
        end
        else
        begin
            mag = (sp < 0) ? -sp : sp;
            pitch = round_q13(vector_angle(sp, floor_root((64'd1 << 60) - mag * mag)));
            e.clamped = 1'b0;
        end
        e.pitch = 15'(pitch);
        return e;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        euler_t want;
        if (!rst_n)
        begin
            fail_count <= 0;
            angles_seen <= 0;
            clamps_seen <= 0;
            angles_due.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                angles_seen <= angles_seen + 1;
                if (angles_due.size() == 0)
                begin
                    $display("%0t: unexpected item roll %0d pitch %0d yaw %0d clamp %0b",
                        $time, roll_angle, pitch_angle, yaw_angle, pitch_clamped);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = angles_due.pop_front();
                    if (want.clamped)
                        clamps_seen <= clamps_seen + 1;
                    if (want.roll !== roll_angle || want.pitch !== pitch_angle ||
                        want.yaw !== yaw_angle || want.clamped !== pitch_clamped)
                    begin
                        $display("%0t: expected roll %0d pitch %0d yaw %0d clamp %0b",
                            $time, want.roll, want.pitch, want.yaw, want.clamped);
                        $display("%0t: actual   roll %0d pitch %0d yaw %0d clamp %0b",
                            $time, roll_angle, pitch_angle, yaw_angle, pitch_clamped);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && !in_stall)
                angles_due.push_back(predict_euler(quat_x, quat_y, quat_z, quat_w));
        end
    end

    assign pending = angles_due.size();

endmodule

// ----- bench/quaternion_to_roll_pitch_yaw_tb.sv -----
module quaternion_to_roll_pitch_yaw_tb;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic               out_valid;
    logic               out_stall;
    logic signed [15:0] roll_angle;
    logic signed [14:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic               pitch_clamped;
    int                 fail_count;
    int                 pending;
    int                 angles_seen;
    int                 clamps_seen;
    int                 items_sent;

    quaternion_to_roll_pitch_yaw u_top (.*);

    quaternion_to_roll_pitch_yaw_checker u_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("quaternion_to_roll_pitch_yaw_tb failed");
        $finish;
    end

    // The receiver stalls in modes that change every so often.
    initial
    begin
        int mode;
        out_stall = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(20, 200))
            begin
                @(posedge clk);
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 1) == 0);
                    default: out_stall <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    task automatic send_quat(logic [15:0] x, logic [15:0] y, logic [15:0] z, logic [15:0] w);
        in_valid <= 1'b1;
        quat_x <= x;
        quat_y <= y;
        quat_z <= z;
        quat_w <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic pause_sender(int n);
        in_valid <= 1'b0;
        repeat (n)
            @(posedge clk);
    endtask

    function automatic logic [15:0] pick_component();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'(int'($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    // Roughly unit quaternion: one large component, the rest small or mid.
    task automatic send_near_unit();
        logic [15:0] c [4];
        int big;
        big = $urandom_range(0, 3);
        for (int i = 0; i < 4; i++)
            c[i] = 16'(int'($urandom_range(0, 23000)) - 11500);
        c[big] = ($urandom_range(0, 1) != 0) ? 16'sd23170 : -16'sd23170;
        if ($urandom_range(0, 3) == 0)
            c[big] = 16'($urandom_range(30000, 32767));
        send_quat(c[0], c[1], c[2], c[3]);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        quat_x = '0;
        quat_y = '0;
        quat_z = '0;
        quat_w = '0;
        items_sent = 0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes, identity, zero vector, half-turns onto the negative real
        // axis, and gimbal lock in both directions.
        send_quat(16'h0000, 16'h0000, 16'h0000, 16'h7FFF);
        send_quat(16'h0000, 16'h0000, 16'h0000, 16'h8000);
        send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_quat(16'h7FFF, 16'h0000, 16'h0000, 16'h0000);
        send_quat(16'h0000, 16'h0000, 16'h7FFF, 16'h0000);
        send_quat(16'h0000, 16'h7FFF, 16'h0000, 16'h0000);
        send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_quat(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
        send_quat(16'h0000, 16'h5A82, 16'h0000, 16'h5A82);
        send_quat(16'h0000, 16'hA57E, 16'h0000, 16'h5A82);
        send_quat(16'h5A82, 16'h0000, 16'h5A82, 16'h0000);
        send_quat(16'h0000, 16'h5A81, 16'h0000, 16'h5A81);
        send_quat(16'h4000, 16'h4000, 16'h4000, 16'h4000);
        send_quat(16'h4000, 16'hC000, 16'h4000, 16'hC000);
        send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0001);
        send_quat(16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
        send_quat(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
        send_quat(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);

        // Let the pipeline drain completely once before the random part.
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);

        while (items_sent < 1130)
        begin
            repeat ($urandom_range(1, 40))
            begin
                if ($urandom_range(0, 3) == 0)
                    send_quat(pick_component(), pick_component(), pick_component(),
                        pick_component());
                else
                    send_near_unit();
            end
            if ($urandom_range(0, 2) != 0)
                pause_sender($urandom_range(1, 12));
        end

        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (80)
            @(posedge clk);

        $display("Sent %0d quaternions, checked %0d angle sets, %0d with pitch clamped.",
            items_sent, angles_seen, clamps_seen);
        if (fail_count == 0 && pending == 0)
            $display("quaternion_to_roll_pitch_yaw_tb passed");
        else
            $display("quaternion_to_roll_pitch_yaw_tb failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/q2rpy_pkg.sv
rtl/q2rpy_sqrt_cell.sv
rtl/q2rpy_cordic_cell.sv
rtl/quaternion_to_roll_pitch_yaw.sv
bench/quaternion_to_roll_pitch_yaw_checker.sv
bench/quaternion_to_roll_pitch_yaw_tb.sv
